FILE: src/lgc_pkg.sv
package lgc_pkg;

    // Store geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W  = $clog2(ENTRIES + 1);

    // Field widths fixed by the word formats.
    localparam int CODE_W = 16;
    localparam int CNT_W  = 16;
    localparam int SLOT_W = 6;

    // Use count saturates here; the least-count search starts above every count.
    localparam logic [CNT_W-1:0] COUNT_SATURATE  = 16'hfffe;
    localparam logic [CNT_W-1:0] COUNT_START_MIN = 16'hffff;

    // One stored entry.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result word.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [CODE_W-1:0] evicted_code;
    } t_rsp;

    // What the scan unit has found so far.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  hit_idx;
        logic [CNT_W-1:0]  hit_cnt;
        logic [IDX_W-1:0]  min_idx;
        logic [CODE_W-1:0] min_code;
    } t_scan_res;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic             clear;
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

endpackage

FILE: src/lgc_if.sv
// Request channel: one character code per word.
interface lgc_req_if;
    logic                       valid;
    logic                       ready;
    logic [lgc_pkg::CODE_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// Response channel: one lookup result per word.
interface lgc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [lgc_pkg::SLOT_W-1:0] slot;
    logic                       evicted;
    logic [lgc_pkg::CODE_W-1:0] evicted_code;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_code, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_code, output ready);
endinterface

FILE: src/lgc_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module lgc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lgc_scan.sv
// Scan unit: looks at one entry per cycle as it comes out of the RAM and
// keeps the first code match and the first entry with the smallest count.
module lgc_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lgc_pkg::t_scan_ctl         i_ctl,
    input  logic [lgc_pkg::CODE_W-1:0] i_code,
    input  lgc_pkg::t_entry            i_entry,
    output lgc_pkg::t_scan_res         o_res
);

    logic                       r_found;
    logic [lgc_pkg::IDX_W-1:0]  r_hit_idx;
    logic [lgc_pkg::CNT_W-1:0]  r_hit_cnt;
    logic [lgc_pkg::CNT_W-1:0]  r_min_cnt;
    logic [lgc_pkg::IDX_W-1:0]  r_min_idx;
    logic [lgc_pkg::CODE_W-1:0] r_min_code;

    logic match;
    logic less;

    assign match = i_ctl.vld && !r_found && (i_entry.code == i_code);
    assign less  = i_ctl.vld && (i_entry.count < r_min_cnt);

    // Match tracking; only the lowest matching slot counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (match) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (match) begin
            r_hit_idx <= i_ctl.idx;
            r_hit_cnt <= i_entry.count;
        end
    end

    // Least-count tracking; a strict compare keeps the lowest slot on ties.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_min_cnt  <= lgc_pkg::COUNT_START_MIN;
            r_min_idx  <= '0;
            r_min_code <= '0;
        end else if (less) begin
            r_min_cnt  <= i_entry.count;
            r_min_idx  <= i_ctl.idx;
            r_min_code <= i_entry.code;
        end
    end

    assign o_res.found    = r_found;
    assign o_res.hit_idx  = r_hit_idx;
    assign o_res.hit_cnt  = r_hit_cnt;
    assign o_res.min_idx  = r_min_idx;
    assign o_res.min_code = r_min_code;

endmodule

FILE: src/lfu_glyph_cache_tags_core.sv
// Channel   Dir  Modport  Word
// i_req     in   sink     char_code
// o_rsp     out  source   hit, slot, evicted, evicted_code
//
// A request passes through these steps: accept, one RAM read per filled
// entry, the registered read, the last compare settling in the scan registers,
// and the write-back.
// The pass ends early on a match. The single RAM read port makes the reads serial.
// Reset clears the fill count but not the store; entries at or above the fill count are never read.
// A finished result waits in the output register while the next request is taken;
// write-back stalls only if that register is still full.
module lfu_glyph_cache_tags_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lgc_req_if.sink    i_req,
    lgc_rsp_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [lgc_pkg::FILL_W-1:0] r_fill;
    logic [lgc_pkg::FILL_W-1:0] r_rd_idx;
    logic                       r_rd_vld;
    logic [lgc_pkg::IDX_W-1:0]  r_chk_idx;
    logic [lgc_pkg::CODE_W-1:0] r_code;
    logic                       r_out_vld;
    lgc_pkg::t_rsp              r_out;

    logic                       accept;
    logic                       issue;
    logic                       scan_done;
    logic                       full;
    logic                       wr_go;
    logic [lgc_pkg::IDX_W-1:0]  w_idx;
    lgc_pkg::t_entry            w_entry;
    lgc_pkg::t_entry            rd_entry;
    logic [lgc_pkg::ENTRY_W-1:0] rd_data;
    lgc_pkg::t_scan_ctl         scan_ctl;
    lgc_pkg::t_scan_res         scan_res;
    lgc_pkg::t_rsp              n_out;

    assign accept    = i_req.valid && i_req.ready;
    assign full      = (r_fill == lgc_pkg::FILL_W'(lgc_pkg::ENTRIES));
    assign issue     = (r_state == S_SCAN) && (r_rd_idx < r_fill) && !scan_res.found;
    assign scan_done = (r_state == S_SCAN) && !issue && !r_rd_vld;
    assign wr_go     = (r_state == S_WRITE) && (!r_out_vld || o_rsp.ready);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept)    n_state = S_SCAN;
            S_SCAN:  if (scan_done) n_state = S_WRITE;
            S_WRITE: if (wr_go)     n_state = S_IDLE;
            default:                n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    // Request code and read address counter.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code <= i_req.char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (accept) begin
                r_rd_idx <= '0;
            end else if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_chk_idx <= r_rd_idx[lgc_pkg::IDX_W-1:0];
        end
    end

    // Tag and count store.
    lgc_ram #(
        .DEPTH (lgc_pkg::ENTRIES),
        .WIDTH (lgc_pkg::ENTRY_W),
        .AW    (lgc_pkg::IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_go),
        .i_waddr (w_idx),
        .i_wdata (w_entry),
        .i_re    (issue),
        .i_raddr (r_rd_idx[lgc_pkg::IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_entry = rd_data;

    // Scan unit fed by the returning read data.
    assign scan_ctl.clear = accept;
    assign scan_ctl.vld   = r_rd_vld;
    assign scan_ctl.idx   = r_chk_idx;

    lgc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_code  (r_code),
        .i_entry (rd_entry),
        .o_res   (scan_res)
    );

    // Write-back: bump on a hit, otherwise fill the next slot or the victim.
    always_comb begin
        w_entry.code = r_code;
        if (scan_res.found) begin
            w_idx = scan_res.hit_idx;
            w_entry.count = (scan_res.hit_cnt < lgc_pkg::COUNT_SATURATE)
                          ? scan_res.hit_cnt + 1'b1 : scan_res.hit_cnt;
        end else if (!full) begin
            w_idx = r_fill[lgc_pkg::IDX_W-1:0];
            w_entry.count = '0;
        end else begin
            w_idx = scan_res.min_idx;
            w_entry.count = '0;
        end
    end

    always_comb begin
        n_out.hit          = scan_res.found;
        n_out.slot         = lgc_pkg::SLOT_W'(w_idx);
        n_out.evicted      = !scan_res.found && full;
        n_out.evicted_code = n_out.evicted ? scan_res.min_code : '0;
    end

    // Fill count grows on a miss into a free slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (wr_go && !scan_res.found && !full) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (wr_go) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.hit          = r_out.hit;
    assign o_rsp.slot         = r_out.slot;
    assign o_rsp.evicted      = r_out.evicted;
    assign o_rsp.evicted_code = r_out.evicted_code;

    // The fill count never passes the store depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= lgc_pkg::FILL_W'(lgc_pkg::ENTRIES))
        else $error("fill count beyond store depth");

    // An accepted word always starts a scan.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted word did not start a scan");

    // A new result is loaded only by a write-back.
    a_out_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_WRITE))
        else $error("result appeared without write-back");

    // No RAM read is outstanding when the write-back happens.
    a_no_read_at_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_go |-> (!r_rd_vld && !issue))
        else $error("read overlaps write-back");

    // Eviction only happens on a miss into a full store.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_go && n_out.evicted) |-> (full && !scan_res.found))
        else $error("eviction without a full store");

endmodule
